[rtl/irfd_pkg.sv]
// shared types, register indexes, reset values and helpers for the ir frame decoder
`timescale 1ns / 1ps

package irfd_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_TICK_ENABLE     = 3'd0;
	localparam logic [2:0] CFG_FRAME_TIMEOUT   = 3'd1;
	localparam logic [2:0] CFG_SONY_END_GAP    = 3'd2;
	localparam logic [2:0] CFG_FIRST_REPEAT    = 3'd3;
	localparam logic [2:0] CFG_REPEAT_INTERVAL = 3'd4;
	localparam logic [2:0] CFG_RELEASE_WINDOW  = 3'd5;

	// register reset values
	localparam logic        RST_TICK_ENABLE     = 1'b1;
	localparam logic [19:0] RST_FRAME_TIMEOUT   = 20'd15000;
	localparam logic [19:0] RST_SONY_END_GAP    = 20'd2800;
	localparam logic [15:0] RST_FIRST_REPEAT    = 16'd650;
	localparam logic [15:0] RST_REPEAT_INTERVAL = 16'd250;
	localparam logic [15:0] RST_RELEASE_WINDOW  = 16'd150;

	// receiver phase codes
	localparam logic [2:0] PH_IDLE       = 3'd0;
	localparam logic [2:0] PH_WAIT_START = 3'd1;
	localparam logic [2:0] PH_SONY_BIT   = 3'd2;
	localparam logic [2:0] PH_NEC_BIT    = 3'd3;
	localparam logic [2:0] PH_OTHER      = 3'd4;

	// valid sony frame lengths and nec frame length
	localparam logic [5:0] SONY_LEN_12 = 6'd12;
	localparam logic [5:0] SONY_LEN_15 = 6'd15;
	localparam logic [5:0] SONY_LEN_20 = 6'd20;
	localparam logic [5:0] NEC_LEN     = 6'd32;

	// configuration register contents
	typedef struct packed {
		logic        tick_enable;
		logic [19:0] frame_timeout_us;
		logic [19:0] sony_end_gap_us;
		logic [15:0] first_repeat_ms;
		logic [15:0] repeat_interval_ms;
		logic [15:0] release_window_ms;
	} cfg_t;

	// decoder result handed to the repeat timer
	typedef struct packed {
		logic        got;
		logic        rx_reset;
		logic [15:0] dev;
		logic [26:0] cmd;
	} dec_t;

	// 32-bit add that saturates at all ones
	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

[rtl/irfd_cfg.sv]
// configuration register bank of the ir frame decoder
`timescale 1ns / 1ps

module irfd_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [19:0]         cfg_data,
	output irfd_pkg::cfg_t      cfg
);

	irfd_pkg::cfg_t cfg_q;

	// register writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_enable        <= irfd_pkg::RST_TICK_ENABLE;
			cfg_q.frame_timeout_us   <= irfd_pkg::RST_FRAME_TIMEOUT;
			cfg_q.sony_end_gap_us    <= irfd_pkg::RST_SONY_END_GAP;
			cfg_q.first_repeat_ms    <= irfd_pkg::RST_FIRST_REPEAT;
			cfg_q.repeat_interval_ms <= irfd_pkg::RST_REPEAT_INTERVAL;
			cfg_q.release_window_ms  <= irfd_pkg::RST_RELEASE_WINDOW;
		end else if (cfg_we) begin
			unique case (cfg_index)
				irfd_pkg::CFG_TICK_ENABLE:     cfg_q.tick_enable        <= cfg_data[0];
				irfd_pkg::CFG_FRAME_TIMEOUT:   cfg_q.frame_timeout_us   <= cfg_data;
				irfd_pkg::CFG_SONY_END_GAP:    cfg_q.sony_end_gap_us    <= cfg_data;
				irfd_pkg::CFG_FIRST_REPEAT:    cfg_q.first_repeat_ms    <= cfg_data[15:0];
				irfd_pkg::CFG_REPEAT_INTERVAL: cfg_q.repeat_interval_ms <= cfg_data[15:0];
				irfd_pkg::CFG_RELEASE_WINDOW:  cfg_q.release_window_ms  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/irfd_decode.sv]
// frame timeout check and sony / nec frame decode
`timescale 1ns / 1ps

module irfd_decode (
	input  logic [2:0]      rx_phase,
	input  logic [19:0]     elapsed_us,
	input  logic [5:0]      bit_count,
	input  logic [31:0]     frame_bits,
	input  irfd_pkg::cfg_t  cfg,
	output irfd_pkg::dec_t  dec
);

	logic timeout;
	logic sony_len;
	logic sony_done;
	logic nec_done;
	logic plain_addr;

	always_comb begin
		// an active frame that has gone silent too long is dropped
		timeout = (rx_phase > irfd_pkg::PH_WAIT_START) && (elapsed_us > cfg.frame_timeout_us);

		sony_len = (bit_count == irfd_pkg::SONY_LEN_12) || (bit_count == irfd_pkg::SONY_LEN_15)
			|| (bit_count == irfd_pkg::SONY_LEN_20);
		sony_done = !timeout && (rx_phase == irfd_pkg::PH_SONY_BIT)
			&& (elapsed_us > cfg.sony_end_gap_us) && sony_len;
		nec_done = !timeout && (rx_phase == irfd_pkg::PH_NEC_BIT)
			&& (bit_count == irfd_pkg::NEC_LEN);

		// plain nec address: top byte is the inverse of the next one
		plain_addr = (frame_bits[31:24] == ~frame_bits[23:16]);

		dec.got      = sony_done || nec_done;
		dec.rx_reset = timeout || sony_done || nec_done;
		dec.dev      = '0;
		dec.cmd      = '0;
		if (sony_done) begin
			dec.dev = {11'd0, frame_bits[11:7]};
			dec.cmd = {frame_bits[31:12], frame_bits[6:0]};
		end else if (nec_done) begin
			dec.dev = plain_addr ? {8'd0, frame_bits[31:24]} : frame_bits[31:16];
			dec.cmd = {19'd0, frame_bits[15:8]};
		end
	end

endmodule

[rtl/irfd_repeat.sv]
// auto-repeat timing: press detection, repeat schedule and release deadline
`timescale 1ns / 1ps

module irfd_repeat (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic            got,
	input  irfd_pkg::cfg_t  cfg,
	output logic            report
);

	logic [31:0] ticks_since_press_q;
	logic [31:0] next_repeat_at_q;
	logic [31:0] release_deadline_q;

	logic        released;
	logic [31:0] t0;
	logic [31:0] n0;
	logic [31:0] n1;

	// a frame after the release deadline starts a new press
	always_comb begin
		released = got && (ticks_since_press_q > release_deadline_q);
		t0 = released ? 32'd0 : ticks_since_press_q;
		n0 = released ? {16'd0, cfg.first_repeat_ms} : next_repeat_at_q;
		report = got && ((t0 == 32'd0) || (t0 > n0));
		n1 = report ? irfd_pkg::sat_add(n0, {16'd0, cfg.repeat_interval_ms}) : n0;
	end

	// timer state advances once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_since_press_q <= '0;
			next_repeat_at_q    <= '0;
			release_deadline_q  <= '0;
		end else if (step) begin
			ticks_since_press_q <= irfd_pkg::sat_add(t0, 32'd1);
			if (got) begin
				next_repeat_at_q   <= n1;
				release_deadline_q <= irfd_pkg::sat_add(t0, {16'd0, cfg.release_window_ms});
			end
		end
	end

endmodule

[rtl/ir_remote_frame_decode_repeat_top.sv]
// top level of the ir remote frame decoder with auto-repeat
`timescale 1ns / 1ps

// channel  | handshake           | word
// ---------+---------------------+--------------------------------------------------
// input    | in_valid / in_ready | rx_phase, elapsed_us, bit_count, frame_bits
// output   | out_valid/out_ready | msg_valid, device_code, command_code, receiver_reset
// config   | cfg_we              | cfg_index, cfg_data
//
// one word in per clock unless the output stalls; each word's result word is offered
// after the input register, then decode and repeat timing into the output register.
// the repeat timer state is updated as a word moves into the output register.
// a stalled output holds its word; the input register still takes one more word.
// arst_n clears control and timer state and loads register reset values.

module ir_remote_frame_decode_repeat_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  rx_phase,
	input  logic [19:0] elapsed_us,
	input  logic [5:0]  bit_count,
	input  logic [31:0] frame_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        msg_valid,
	output logic [15:0] device_code,
	output logic [26:0] command_code,
	output logic        receiver_reset,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data
);

	irfd_pkg::cfg_t cfg;
	irfd_pkg::dec_t dec;

	logic        valid_s1;
	logic [2:0]  phase_s1;
	logic [19:0] elapsed_s1;
	logic [5:0]  count_s1;
	logic [31:0] bits_s1;

	logic        out_valid_q;
	logic        msg_valid_q;
	logic [15:0] device_q;
	logic [26:0] command_q;
	logic        rx_reset_q;

	logic        adv;
	logic        step;
	logic        report;

	irfd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves on when the output register is free or drained
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign step     = adv && cfg.tick_enable;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			phase_s1   <= rx_phase;
			elapsed_s1 <= elapsed_us;
			count_s1   <= bit_count;
			bits_s1    <= frame_bits;
		end
	end

	irfd_decode u_decode (
		.rx_phase   (phase_s1),
		.elapsed_us (elapsed_s1),
		.bit_count  (count_s1),
		.frame_bits (bits_s1),
		.cfg        (cfg),
		.dec        (dec)
	);

	irfd_repeat u_repeat (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.got    (dec.got),
		.cfg    (cfg),
		.report (report)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word, all zero when ticks are disabled
	always_ff @(posedge clk) begin
		if (adv) begin
			msg_valid_q <= cfg.tick_enable && report;
			device_q    <= (cfg.tick_enable && report) ? dec.dev : 16'd0;
			command_q   <= (cfg.tick_enable && report) ? dec.cmd : 27'd0;
			rx_reset_q  <= cfg.tick_enable && dec.rx_reset;
		end
	end

	assign out_valid      = out_valid_q;
	assign msg_valid      = msg_valid_q;
	assign device_code    = device_q;
	assign command_code   = command_q;
	assign receiver_reset = rx_reset_q;

	// a report always comes from a consumed frame
	a_report_resets: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && msg_valid |-> receiver_reset)
		else $error("key report without receiver reset");

	// no report means zero device and command
	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !msg_valid |-> device_code == 16'd0 && command_code == 27'd0)
		else $error("nonzero codes without a report");

	// input stalls only when both registers are full and the output is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");

	// timer state moves only with a word entering the output register
	a_step_adv: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("timer stepped without an output word");

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the ir remote frame decoder with auto-repeat
`timescale 1ns / 1ps

module tb;

	// one expected output word
	typedef struct {
		logic        msg_valid;
		logic [15:0] device_code;
		logic [26:0] command_code;
		logic        receiver_reset;
	} key_report_t;

	// tracks decoder and repeat timer state, holds the reports still owed by the block
	class ir_report_scoreboard;
		irfd_pkg::cfg_t regs;
		logic [31:0]   press_age;
		logic [31:0]   repeat_due;
		logic [31:0]   release_at;
		key_report_t   owed[$];
		int            errors;
		int            accepted;

		function new();
			regs.tick_enable        = irfd_pkg::RST_TICK_ENABLE;
			regs.frame_timeout_us   = irfd_pkg::RST_FRAME_TIMEOUT;
			regs.sony_end_gap_us    = irfd_pkg::RST_SONY_END_GAP;
			regs.first_repeat_ms    = irfd_pkg::RST_FIRST_REPEAT;
			regs.repeat_interval_ms = irfd_pkg::RST_REPEAT_INTERVAL;
			regs.release_window_ms  = irfd_pkg::RST_RELEASE_WINDOW;
			press_age  = '0;
			repeat_due = '0;
			release_at = '0;
			errors     = 0;
			accepted   = 0;
		endfunction

		function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
			logic [32:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[32] ? 32'hFFFF_FFFF : s[31:0];
		endfunction

		function void write_reg(logic [2:0] idx, logic [19:0] data);
			case (idx)
				irfd_pkg::CFG_TICK_ENABLE:     regs.tick_enable        = data[0];
				irfd_pkg::CFG_FRAME_TIMEOUT:   regs.frame_timeout_us   = data;
				irfd_pkg::CFG_SONY_END_GAP:    regs.sony_end_gap_us    = data;
				irfd_pkg::CFG_FIRST_REPEAT:    regs.first_repeat_ms    = data[15:0];
				irfd_pkg::CFG_REPEAT_INTERVAL: regs.repeat_interval_ms = data[15:0];
				irfd_pkg::CFG_RELEASE_WINDOW:  regs.release_window_ms  = data[15:0];
				default: ;
			endcase
		endfunction

		// decode one tick and advance the repeat timer
		function void note_tick(logic [2:0] phase, logic [19:0] elapsed, logic [5:0] count,
				logic [31:0] fbits);
			key_report_t r;
			logic [2:0]  ph;
			logic        got;
			logic [31:0] w;
			logic [15:0] dev;
			logic [26:0] cmd;
			r.msg_valid      = 1'b0;
			r.device_code    = '0;
			r.command_code   = '0;
			r.receiver_reset = 1'b0;
			accepted++;
			if (regs.tick_enable) begin
				ph  = phase;
				got = 1'b0;
				w   = fbits;
				dev = '0;
				cmd = '0;
				// stalled frame abort
				if (ph > irfd_pkg::PH_WAIT_START && elapsed > regs.frame_timeout_us) begin
					r.receiver_reset = 1'b1;
					ph = irfd_pkg::PH_IDLE;
				end
				// sony frame ends on a long enough gap
				if (ph == irfd_pkg::PH_SONY_BIT && elapsed > regs.sony_end_gap_us &&
						(count == irfd_pkg::SONY_LEN_12 || count == irfd_pkg::SONY_LEN_15 ||
						count == irfd_pkg::SONY_LEN_20)) begin
					dev = {11'd0, w[11:7]};
					cmd = {w[31:12], w[6:0]};
					got = 1'b1;
				end
				// nec frame, plain address folds the inverted byte away
				if (ph == irfd_pkg::PH_NEC_BIT && count == irfd_pkg::NEC_LEN) begin
					if (w[31:24] == ~w[23:16])
						w = {8'h00, w[31:24], w[15:0]};
					dev = w[31:16];
					cmd = {19'd0, w[15:8]};
					got = 1'b1;
				end
				// auto-repeat timing
				if (got) begin
					if (press_age > release_at) begin
						press_age  = '0;
						repeat_due = {16'd0, regs.first_repeat_ms};
					end
					if (press_age == 0 || press_age > repeat_due) begin
						r.msg_valid    = 1'b1;
						r.device_code  = dev;
						r.command_code = cmd;
						repeat_due = add_sat(repeat_due, {16'd0, regs.repeat_interval_ms});
					end
					release_at = add_sat(press_age, {16'd0, regs.release_window_ms});
					r.receiver_reset = 1'b1;
				end
				press_age = add_sat(press_age, 32'd1);
			end
			owed.push_back(r);
		endfunction

		function void check_report(logic mv, logic [15:0] dev, logic [26:0] cmd, logic rr);
			key_report_t e;
			if (owed.size() == 0) begin
				$display("%0t: unexpected word msg_valid %b device %h command %h reset %b",
					$time, mv, dev, cmd, rr);
				errors++;
				return;
			end
			e = owed.pop_front();
			if (mv !== e.msg_valid) begin
				$display("%0t: msg_valid expected %b got %b", $time, e.msg_valid, mv);
				errors++;
			end
			if (dev !== e.device_code) begin
				$display("%0t: device_code expected %h got %h", $time, e.device_code, dev);
				errors++;
			end
			if (cmd !== e.command_code) begin
				$display("%0t: command_code expected %h got %h", $time, e.command_code, cmd);
				errors++;
			end
			if (rr !== e.receiver_reset) begin
				$display("%0t: receiver_reset expected %b got %b", $time, e.receiver_reset, rr);
				errors++;
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  rx_phase;
	logic [19:0] elapsed_us;
	logic [5:0]  bit_count;
	logic [31:0] frame_bits;
	logic        out_valid;
	logic        out_ready;
	logic        msg_valid;
	logic [15:0] device_code;
	logic [26:0] command_code;
	logic        receiver_reset;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [19:0] cfg_data;

	ir_report_scoreboard sb = new();
	bit calm = 1'b1;
	bit held_off = 1'b0;

	ir_remote_frame_decode_repeat_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_phase       (rx_phase),
		.elapsed_us     (elapsed_us),
		.bit_count      (bit_count),
		.frame_bits     (frame_bits),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.msg_valid      (msg_valid),
		.device_code    (device_code),
		.command_code   (command_code),
		.receiver_reset (receiver_reset),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #6 clk = ~clk;

	// mostly short idle runs, now and then a long one
	function automatic int idle_len();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// offer one word and hold it until taken
	task automatic send_word(logic [2:0] ph, logic [19:0] el, logic [5:0] cnt, logic [31:0] fb);
		int gap;
		in_valid   <= 1'b1;
		rx_phase   <= ph;
		elapsed_us <= el;
		bit_count  <= cnt;
		frame_bits <= fb;
		@(negedge clk);
		while (!in_ready)
			@(negedge clk);
		@(posedge clk);
		sb.note_tick(ph, el, cnt, fb);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = idle_len();
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [2:0] idx, logic [19:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic write_all(logic en, logic [19:0] tmo, logic [19:0] gap, logic [15:0] first,
			logic [15:0] intv, logic [15:0] win);
		write_reg(irfd_pkg::CFG_TICK_ENABLE, {19'd0, en});
		write_reg(irfd_pkg::CFG_FRAME_TIMEOUT, tmo);
		write_reg(irfd_pkg::CFG_SONY_END_GAP, gap);
		write_reg(irfd_pkg::CFG_FIRST_REPEAT, {4'd0, first});
		write_reg(irfd_pkg::CFG_REPEAT_INTERVAL, {4'd0, intv});
		write_reg(irfd_pkg::CFG_RELEASE_WINDOW, {4'd0, win});
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [19:0] just_above(logic [19:0] v);
		return (v == 20'hFFFFF) ? v : v + 20'd1;
	endfunction

	// one random tick: mostly well-formed frames near the thresholds, some idle and noise
	task automatic random_tick();
		logic [2:0]  ph;
		logic [19:0] el;
		logic [5:0]  cnt;
		logic [31:0] fb;
		int          kind;
		kind = $urandom_range(0, 99);
		fb = $urandom;
		if (kind < 35) begin
			ph = irfd_pkg::PH_SONY_BIT;
			case ($urandom_range(0, 3))
				0: cnt = irfd_pkg::SONY_LEN_12;
				1: cnt = irfd_pkg::SONY_LEN_15;
				2: cnt = irfd_pkg::SONY_LEN_20;
				default: cnt = 6'($urandom_range(0, 63));
			endcase
			case ($urandom_range(0, 4))
				0, 1: el = just_above(sb.regs.sony_end_gap_us);
				2: el = sb.regs.sony_end_gap_us;
				3: el = 20'($urandom_range(0, 20'hFFFFF));
				default: el = just_above(sb.regs.frame_timeout_us);
			endcase
		end else if (kind < 65) begin
			ph  = irfd_pkg::PH_NEC_BIT;
			cnt = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63)) : irfd_pkg::NEC_LEN;
			if ($urandom_range(0, 1))
				fb[23:16] = ~fb[31:24];
			case ($urandom_range(0, 5))
				0: el = just_above(sb.regs.frame_timeout_us);
				1: el = sb.regs.frame_timeout_us;
				default: el = 20'($urandom_range(0, 2000));
			endcase
		end else if (kind < 85) begin
			ph  = 3'($urandom_range(0, 1));
			el  = 20'($urandom_range(0, 20'hFFFFF));
			cnt = 6'($urandom_range(0, 63));
		end else begin
			ph  = 3'($urandom_range(0, 7));
			el  = 20'($urandom_range(0, 20'hFFFFF));
			cnt = 6'($urandom_range(0, 63));
		end
		send_word(ph, el, cnt, fb);
	endtask

	task automatic random_run(int n);
		repeat (n) random_tick();
	endtask

	// receiver: random stalls, plus one long hold-off once traffic is flowing
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && sb.accepted >= 60) begin
				out_ready <= 1'b0;
				repeat (60) @(posedge clk);
				held_off = 1'b1;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (idle_len()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// output monitor, sampled mid-cycle ahead of the accepting edge
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid && out_ready)
			sb.check_report(msg_valid, device_code, command_code, receiver_reset);
	end

	// run limit
	initial begin
		#2_400_000;
		$display("simulation failed");
		$finish;
	end

	// stimulus
	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		rx_phase   <= irfd_pkg::PH_IDLE;
		elapsed_us <= '0;
		bit_count  <= '0;
		frame_bits <= '0;
		cfg_we     <= 1'b0;
		cfg_index  <= irfd_pkg::CFG_TICK_ENABLE;
		cfg_data   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words on reset settings, first frame lands at tick zero
		send_word(irfd_pkg::PH_NEC_BIT, 20'd500, irfd_pkg::NEC_LEN, 32'h10EF_45BA);
		send_word(irfd_pkg::PH_IDLE, 20'd0, 6'd0, 32'h0);
		send_word(irfd_pkg::PH_WAIT_START, 20'hFFFFF, 6'd63, 32'hFFFF_FFFF);
		send_word(irfd_pkg::PH_SONY_BIT, 20'd2801, irfd_pkg::SONY_LEN_12, 32'h0000_0ABC);
		send_word(irfd_pkg::PH_SONY_BIT, 20'd2800, irfd_pkg::SONY_LEN_15, 32'h0000_7FFF);
		send_word(irfd_pkg::PH_SONY_BIT, 20'd2801, irfd_pkg::SONY_LEN_15, 32'h0000_7FFF);
		send_word(irfd_pkg::PH_SONY_BIT, 20'd15000, irfd_pkg::SONY_LEN_20, 32'hFFFF_FFFF);
		send_word(irfd_pkg::PH_SONY_BIT, 20'd15001, irfd_pkg::SONY_LEN_20, 32'hFFFF_FFFF);
		send_word(irfd_pkg::PH_SONY_BIT, 20'd3000, 6'd13, 32'h0000_1234);
		send_word(irfd_pkg::PH_SONY_BIT, 20'hFFFFF, irfd_pkg::SONY_LEN_12, 32'h0000_0FFF);
		send_word(irfd_pkg::PH_NEC_BIT, 20'd0, irfd_pkg::NEC_LEN, 32'h1234_5678);
		send_word(irfd_pkg::PH_NEC_BIT, 20'd0, irfd_pkg::NEC_LEN, 32'h0000_0000);
		send_word(irfd_pkg::PH_NEC_BIT, 20'd0, irfd_pkg::NEC_LEN, 32'hFFFF_FFFF);
		send_word(irfd_pkg::PH_NEC_BIT, 20'd100, irfd_pkg::NEC_LEN, 32'hFF00_AA55);
		send_word(irfd_pkg::PH_NEC_BIT, 20'd100, 6'd31, 32'h10EF_45BA);
		send_word(irfd_pkg::PH_NEC_BIT, 20'hFFFFF, 6'd63, 32'h10EF_45BA);
		send_word(irfd_pkg::PH_NEC_BIT, 20'd15001, irfd_pkg::NEC_LEN, 32'h10EF_45BA);
		send_word(irfd_pkg::PH_OTHER, 20'd20000, 6'd5, 32'h0);
		send_word(irfd_pkg::PH_OTHER, 20'd100, 6'd5, 32'h0);
		// phase values past the defined codes act as other
		send_word(3'd5, 20'd15001, irfd_pkg::NEC_LEN, 32'hA5A5_A5A5);
		send_word(3'd6, 20'd10, irfd_pkg::SONY_LEN_12, 32'h0000_0FFF);
		send_word(3'd7, 20'hFFFFF, irfd_pkg::NEC_LEN, 32'h5A5A_5A5A);
		in_valid <= 1'b0;
		drain();

		// short repeat timing so holds and releases both happen often
		calm = 1'b0;
		write_all(1'b1, 20'd5000, 20'd2000, 16'd3, 16'd2, 16'd6);
		random_run(170);
		in_valid <= 1'b0;
		drain();

		// all thresholds and timers at zero
		write_all(1'b1, 20'd0, 20'd0, 16'd0, 16'd0, 16'd0);
		random_run(60);
		in_valid <= 1'b0;
		drain();

		// all thresholds and timers at their maximum
		write_all(1'b1, 20'hFFFFF, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_run(50);
		in_valid <= 1'b0;
		drain();

		// ticks ignored
		write_reg(irfd_pkg::CFG_TICK_ENABLE, 20'd0);
		cfg_we <= 1'b0;
		random_run(30);
		in_valid <= 1'b0;
		drain();

		// moderate timing, first a burst with no idling, then random idling again
		write_all(1'b1, 20'd15000, 20'd2800, 16'd10, 16'd4, 16'd12);
		calm = 1'b1;
		random_run(40);
		calm = 1'b0;
		random_run(80);
		in_valid <= 1'b0;
		drain();

		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
rtl/irfd_pkg.sv
rtl/irfd_cfg.sv
rtl/irfd_decode.sv
rtl/irfd_repeat.sv
rtl/ir_remote_frame_decode_repeat_top.sv
tb/sv/tb.sv
